// ===== src/qgap_pkg.sv =====
package qgap_pkg;

  localparam int QGAP_MAX_CHANNELS = 256;

  localparam int SAMPLE_W  = 8;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 26;
  localparam int DEC_W     = 9;
  localparam int MULT_W    = 31;
  localparam int SHIFT_W   = 6;
  localparam int ZP_W      = 8;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam int QCLIP_W   = 13;

  localparam logic [QCLIP_W-1:0] MEAN_MAX   = 13'd4096;
  localparam logic [QCLIP_W-1:0] MEAN_OVER  = 13'd4097;
  localparam logic signed [14:0] POOL_MIN   = -15'sd128;
  localparam logic signed [14:0] POOL_MAX   = 15'sd127;

  localparam logic [MULT_W-1:0]  MULT_RESET  = 31'h4000_0000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd30;

  typedef enum logic [1:0] {
    REG_IN_ZP     = 2'd0,
    REG_OUT_ZP    = 2'd1,
    REG_SCALE_MUL = 2'd2,
    REG_SCALE_SH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
    logic                last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        out_channel;
    logic signed [ZP_W-1:0]   pooled_value;
  } out_item_t;

  // Final sum of a channel, handed from the accumulator to the requantiser.
  typedef struct packed {
    logic                    vld;
    logic [CHAN_W-1:0]       channel;
    logic signed [SUM_W-1:0] sum;
  } acc_res_t;

endpackage

// ===== src/qgap_ram.sv =====
module qgap_ram import qgap_pkg::*; #(
  parameter int WIDTH = SUM_W,
  parameter int DEPTH = QGAP_MAX_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/qgap_accum.sv =====
module qgap_accum import qgap_pkg::*; #(
  parameter int MAX_CHANNELS = QGAP_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   adv,
  input  logic signed [ZP_W-1:0] in_zp,
  output acc_res_t               res
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                    clearing_r, clearing_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;

  logic                    s1_valid_r;
  logic                    s1_last_r;
  logic [CHAN_W-1:0]       s1_chan_r;
  logic [AW-1:0]           s1_addr_r;
  logic signed [DEC_W-1:0] s1_dec_r;

  logic                    wb_vld_r;
  logic [AW-1:0]           wb_addr_r;
  logic [SUM_W-1:0]        wb_data_r;

  logic [31:0]             ch_ext;
  logic [AW-1:0]           rd_addr;
  logic                    ch_ok;
  logic                    accept;
  logic                    take;
  logic [SAMPLE_W-1:0]     shifted;
  logic signed [9:0]       dec_wide;
  logic [SUM_W-1:0]        rdata;
  logic [SUM_W-1:0]        base;
  logic [SUM_W-1:0]        acc;
  logic                    s1_wr;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [SUM_W-1:0]        ram_wdata;

  assign ch_ext   = 32'(in_data.channel);
  assign rd_addr  = ch_ext[AW-1:0];
  assign ch_ok    = ch_ext < 32'(MAX_CHANNELS);
  assign in_ready = adv && !clearing_r;
  assign accept   = in_valid && in_ready;
  assign take     = accept && ch_ok;

  // The byte is re-centred on the zero point, wrapped to eight bits and then
  // the zero point is taken off again.
  assign shifted  = in_data.sample + in_zp;
  assign dec_wide = 10'($signed({{2{shifted[7]}}, shifted})) -
                    10'($signed({{2{in_zp[7]}}, in_zp}));

  // The latest write wins over the RAM read, which may predate it.
  assign base  = (wb_vld_r && wb_addr_r == s1_addr_r) ? wb_data_r : rdata;
  assign acc   = base + SUM_W'(s1_dec_r);
  assign s1_wr = s1_valid_r && adv;

  assign ram_we    = clearing_r || s1_wr;
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = (clearing_r || s1_last_r) ? '0 : acc;

  qgap_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CHANNELS)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign res.vld     = s1_valid_r && s1_last_r;
  assign res.channel = s1_chan_r;
  assign res.sum     = $signed(acc);

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MAX_CHANNELS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      wb_vld_r   <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      if (adv) begin
        s1_valid_r <= take;
      end
      if (s1_wr) begin
        wb_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_last_r <= in_data.last_pixel;
      s1_chan_r <= in_data.channel;
      s1_addr_r <= rd_addr;
      s1_dec_r  <= dec_wide[DEC_W-1:0];
    end
    if (s1_wr) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= ram_wdata;
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r)
    else $error("an item reached the accumulate stage during the clearing pass");

  a_last_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && adv) |=> (wb_vld_r && wb_data_r == '0))
    else $error("a channel's final pixel did not clear its accumulator");

  a_stalled_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_dec_r)))
    else $error("the accumulate stage lost an item while stalled");

endmodule

// ===== src/qgap_requant.sv =====
module qgap_requant import qgap_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  acc_res_t                res,
  input  logic [MULT_W-1:0]       scale_mul,
  input  logic [SHIFT_W-1:0]      scale_sh,
  input  logic signed [ZP_W-1:0]  out_zp,
  output logic                    adv,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data
);

  logic               p2_vld_r;
  logic               p2_neg_r;
  logic [CHAN_W-1:0]  p2_chan_r;
  logic [SUM_W-1:0]   p2_mag_r;

  logic               p3_vld_r;
  logic               p3_neg_r;
  logic [CHAN_W-1:0]  p3_chan_r;
  logic [PROD_W-1:0]  p3_prod_r;

  logic               p4_vld_r;
  logic               p4_neg_r;
  logic [CHAN_W-1:0]  p4_chan_r;
  logic [QCLIP_W-1:0] p4_q_r;
  logic               p4_rnd_r;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic [SUM_W-1:0]   mag;
  logic [63:0]        prod_ext;
  logic [63:0]        q_full;
  logic [63:0]        rem;
  logic [63:0]        half;
  logic               rnd;
  logic [QCLIP_W-1:0] q_clip;
  logic [13:0]        q_rnd;
  logic [QCLIP_W-1:0] q_sat;
  logic signed [14:0] mean;
  logic signed [14:0] biased;
  logic signed [7:0]  pooled;

  // Everything moves together unless a finished result is blocked while the rounding stage holds another.
  assign adv = !out_valid_r || out_ready || !p4_vld_r;

  assign mag = res.sum[SUM_W-1] ? SUM_W'(-res.sum) : SUM_W'(res.sum);

  // Shift on the magnitude and round ties to even; a zero shift is exact.
  assign prod_ext = 64'(p3_prod_r);
  assign q_full   = prod_ext >> scale_sh;
  assign rem      = prod_ext & ((64'd1 << scale_sh) - 64'd1);
  assign half     = (scale_sh == '0) ? 64'd0 : (64'd1 << (scale_sh - 1'b1));
  assign rnd      = (scale_sh != '0) && ((rem > half) || (rem == half && q_full[0]));
  assign q_clip   = (q_full > 64'(MEAN_MAX)) ? MEAN_OVER : q_full[QCLIP_W-1:0];

  assign q_rnd  = {1'b0, p4_q_r} + 14'(p4_rnd_r);
  assign q_sat  = (q_rnd > 14'(MEAN_MAX)) ? MEAN_MAX : q_rnd[QCLIP_W-1:0];
  assign mean   = p4_neg_r ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
  assign biased = mean + 15'(out_zp);

  always_comb begin
    if (biased < POOL_MIN) begin
      pooled = POOL_MIN[7:0];
    end else if (biased > POOL_MAX) begin
      pooled = POOL_MAX[7:0];
    end else begin
      pooled = biased[7:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && p4_vld_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        p2_vld_r <= res.vld;
        p3_vld_r <= p2_vld_r;
        p4_vld_r <= p3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_neg_r  <= res.sum[SUM_W-1];
      p2_chan_r <= res.channel;
      p2_mag_r  <= mag;
      p3_neg_r  <= p2_neg_r;
      p3_chan_r <= p2_chan_r;
      p3_prod_r <= p2_mag_r * scale_mul;
      p4_neg_r  <= p3_neg_r;
      p4_chan_r <= p3_chan_r;
      p4_q_r    <= q_clip;
      p4_rnd_r  <= rnd;
    end
    if (adv && p4_vld_r) begin
      out_data_r.out_channel  <= p4_chan_r;
      out_data_r.pooled_value <= pooled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_blocked_result_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && p4_vld_r) |-> !adv)
    else $error("pipeline advanced over a result that could not be delivered");

  a_stalled_tail_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (p4_vld_r && !adv) |=> (p4_vld_r && $stable(p4_q_r) && $stable(p4_chan_r)))
    else $error("a result waiting in the rounding stage was lost");

  a_offered_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("an offered result changed or vanished before it was taken");

endmodule

// ===== src/quantized_global_average_pool_core.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_item_t: sample, channel, last_pixel
// out_     output     out_valid / out_ready  out_item_t: out_channel, pooled_value
// cfg_     input      cfg_we                 cfg_index selects register, cfg_wdata
//
// One item is taken every cycle unless the pipeline stalls or the clearing pass runs; each
// reads its channel sum from the RAM and writes it back, with the last write forwarded so
// that repeated channels do not stall. A finished sum passes the p2, p3 and p4 stages into
// the output register. After reset a clearing pass writes zero to every sum, with in_ready low.
// A blocked result stalls the whole pipeline only while the rounding stage holds a result.
module quantized_global_average_pool_core import qgap_pkg::*; #(
  parameter int MAX_CHANNELS = QGAP_MAX_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [MULT_W-1:0] cfg_wdata
);

  logic signed [ZP_W-1:0] in_zp_r;
  logic signed [ZP_W-1:0] out_zp_r;
  logic [MULT_W-1:0]      scale_mul_r;
  logic [SHIFT_W-1:0]     scale_sh_r;

  logic                   adv;
  acc_res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_zp_r     <= '0;
      out_zp_r    <= '0;
      scale_mul_r <= MULT_RESET;
      scale_sh_r  <= SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IN_ZP:     in_zp_r     <= cfg_wdata[ZP_W-1:0];
        REG_OUT_ZP:    out_zp_r    <= cfg_wdata[ZP_W-1:0];
        REG_SCALE_MUL: scale_mul_r <= cfg_wdata;
        REG_SCALE_SH:  scale_sh_r  <= cfg_wdata[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qgap_accum #(.MAX_CHANNELS(MAX_CHANNELS)) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .in_zp    (in_zp_r),
    .res      (res)
  );

  qgap_requant u_requant (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .scale_mul (scale_mul_r),
    .scale_sh  (scale_sh_r),
    .out_zp    (out_zp_r),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
